FILE: src/hhm_pkg.sv
package hhm_pkg;

	// Operation codes carried in s_tuser
	typedef enum logic [1:0] {
		OP_REGISTER   = 2'd0,
		OP_UNREGISTER = 2'd1,
		OP_REPORT     = 2'd2
	} op_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_FLOOD_EN   = 3'd0,
		CFG_RATE_LIMIT = 3'd1,
		CFG_LAT_LIMIT  = 3'd2,
		CFG_JIT_LIMIT  = 3'd3,
		CFG_BW_FLOOR   = 3'd4
	} cfg_idx_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_READ,
		ST_SUM,
		ST_FINISH
	} state_t;

	// Input item, packed so that host_slot sits in the lowest bits
	typedef struct packed {
		logic [7:0]  error_total;
		logic [15:0] conn_rate;
		logic [15:0] bandwidth_up;
		logic [15:0] bandwidth_down;
		logic [13:0] loss_rate;
		logic [15:0] jitter;
		logic [15:0] latency;
		logic [9:0]  memory_load;
		logic [9:0]  cpu_load;
		logic [5:0]  host_slot;
	} metrics_t;

	// Result item, accepted in the lowest bit
	typedef struct packed {
		logic       flood_suspected;
		logic [7:0] failure_count;
		logic       degraded;
		logic       report_ok;
		logic [6:0] score;
		logic       accepted;
	} result_t;

	// Configuration registers
	typedef struct packed {
		logic        flood_en;
		logic [15:0] rate_limit;
		logic [15:0] lat_limit;
		logic [15:0] jit_limit;
		logic [15:0] bw_floor;
	} limits_t;

	// Evaluator outputs
	typedef struct packed {
		logic       limits_ok;
		logic       rate_over;
		logic [6:0] score;
	} eval_t;

	localparam int LAT_W        = 16;
	localparam int SUM_W        = 18;
	localparam int TDATA_IN_W   = 128;
	localparam int TDATA_OUT_W  = 24;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	// Reset values of the configuration registers
	localparam int RST_FLOOD_EN   = 1;
	localparam int RST_RATE_LIMIT = 1000;
	localparam int RST_LAT_LIMIT  = 1500;
	localparam int RST_JIT_LIMIT  = 300;
	localparam int RST_BW_FLOOR   = 100;

	// Validation limits
	localparam int CPU_MAX  = 900;
	localparam int MEM_MAX  = 950;
	localparam int LOSS_MAX = 100;
	localparam int ERR_MAX  = 10;

	// Score, in hundredths of a point
	localparam int SCORE_FULL   = 10000;
	localparam int CPU_KNEE     = 800;
	localparam int MEM_KNEE     = 850;
	localparam int LAT_KNEE     = 1000;
	localparam int LOAD_PENALTY = 20;
	localparam int ERR_PENALTY  = 500;
	// floor(x / 100) == (x * 5243) >> 19 for x up to 10000
	localparam int DIV100_MULT  = 5243;
	localparam int DIV100_SHIFT = 19;

	// Failure tracking and surge test
	localparam int FAIL_MAX      = 255;
	localparam int FAIL_DEGRADE  = 3;
	localparam int SURGE_WINDOW  = 3;
	localparam int SURGE_FACTOR  = 3;

endpackage

FILE: src/hhm_slot_mem.sv
module hhm_slot_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 26
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// one registered read port, data held between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: src/hhm_hist_mem.sv
module hhm_hist_mem #(
	parameter int DEPTH = 640
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [$clog2(DEPTH)-1:0]      wr_addr,
	input  logic [hhm_pkg::LAT_W-1:0]     wr_data,
	input  logic                          rd_en,
	input  logic [$clog2(DEPTH)-1:0]      rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0]      rd_addr_b,
	output logic [hhm_pkg::LAT_W-1:0]     rd_data_a,
	output logic [hhm_pkg::LAT_W-1:0]     rd_data_b
);

	import hhm_pkg::*;

	logic [LAT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// two registered read ports
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

FILE: src/hhm_eval.sv
module hhm_eval (
	input  logic             clk,
	input  hhm_pkg::metrics_t item,
	input  hhm_pkg::limits_t  limits,
	output hhm_pkg::eval_t    result
);

	import hhm_pkg::*;

	logic [9:0]       cpu_ex;
	logic [9:0]       mem_ex;
	logic [15:0]      lat_ex;
	logic [SUM_W-1:0] penalty;
	logic [13:0]      hund;
	logic             limits_ok;
	logic             rate_over;
	logic [13:0]      hund_s1;
	logic             limits_ok_s1;
	logic             rate_over_s1;
	logic [26:0]      prod;

	// excess over each knee
	assign cpu_ex = (item.cpu_load > 10'(CPU_KNEE)) ? item.cpu_load - 10'(CPU_KNEE) : '0;
	assign mem_ex = (item.memory_load > 10'(MEM_KNEE)) ?
		item.memory_load - 10'(MEM_KNEE) : '0;
	assign lat_ex = (item.latency > 16'(LAT_KNEE)) ? item.latency - 16'(LAT_KNEE) : '0;

	// total penalty in hundredths, then clamp against the full score
	assign penalty = SUM_W'(cpu_ex) * SUM_W'(LOAD_PENALTY)
		+ SUM_W'(mem_ex) * SUM_W'(LOAD_PENALTY)
		+ SUM_W'(lat_ex)
		+ SUM_W'(item.error_total) * SUM_W'(ERR_PENALTY);
	assign hund = (penalty >= SUM_W'(SCORE_FULL)) ? '0 : 14'(SUM_W'(SCORE_FULL) - penalty);

	// limit checks, flood flag excluded
	assign limits_ok = (item.latency <= limits.lat_limit)
		&& (item.jitter <= limits.jit_limit)
		&& (item.loss_rate <= 14'(LOSS_MAX))
		&& (item.bandwidth_down >= limits.bw_floor)
		&& (item.bandwidth_up >= limits.bw_floor)
		&& (item.cpu_load < 10'(CPU_MAX))
		&& (item.memory_load < 10'(MEM_MAX))
		&& (item.error_total < 8'(ERR_MAX));

	assign rate_over = limits.flood_en && (item.conn_rate > limits.rate_limit);

	// stage 1: clamped score and checks
	always_ff @(posedge clk) begin
		hund_s1      <= hund;
		limits_ok_s1 <= limits_ok;
		rate_over_s1 <= rate_over;
	end

	// stage 2: divide by 100 through reciprocal multiply
	assign prod = 27'(hund_s1) * 27'(DIV100_MULT);

	always_ff @(posedge clk) begin
		result.score     <= prod[DIV100_SHIFT +: 7];
		result.limits_ok <= limits_ok_s1;
		result.rate_over <= rate_over_s1;
	end

endmodule

FILE: src/host_health_monitor_top.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: metrics item, s_tuser: operation
// m_*       out  m_tvalid/m_tready  m_tdata: result item
// cfg_*     in   cfg_wr_en          cfg_index, cfg_wdata
//
// A metrics report on a registered slot takes a slot memory lookup, two-port history reads
// and a sum, then the write-back. Register and unregister items take only the lookup and
// the write-back; refused items are looked up and not written back.
// After reset a clearing pass zeroes every slot of the slot memory; s_tready is low.
// A finished result waits in the output register; the next item is accepted meanwhile,
// and its write-back waits until that register is free.
module host_health_monitor_top #(
	parameter int HOST_SLOTS    = 64,
	parameter int HISTORY_DEPTH = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// s_tdata, low bit up: host_slot, cpu_load, memory_load, latency, jitter,
	// loss_rate, bandwidth_down, bandwidth_up, conn_rate, error_total
	input  logic [hhm_pkg::TDATA_IN_W-1:0]     s_tdata,
	// s_tuser: operation
	input  logic [1:0]                         s_tuser,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// m_tdata, low bit up: accepted, score, report_ok, degraded, failure_count,
	// flood_suspected, zero fill
	output logic [hhm_pkg::TDATA_OUT_W-1:0]    m_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic                               cfg_wr_en,
	input  logic [hhm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hhm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	import hhm_pkg::*;

	localparam int SW       = (HOST_SLOTS > 1) ? $clog2(HOST_SLOTS) : 1;
	localparam int HIST_N   = HOST_SLOTS * HISTORY_DEPTH;
	localparam int HAW      = $clog2(HIST_N);
	localparam int PW       = $clog2(HISTORY_DEPTH);
	localparam int FW       = $clog2(HISTORY_DEPTH + 1);
	localparam int TW       = PW + 2;
	localparam int REC_W    = 18 + PW + FW;
	localparam int SURGE_W  = SUM_W + 2;

	state_t           state_q, state_d;
	logic [SW-1:0]    clr_cnt_q;
	limits_t          limits_q;

	// item registers
	metrics_t         in_item;
	metrics_t         item_q;
	op_t              op_q;
	logic             in_range_q;
	logic [SW-1:0]    slot_q;
	logic [HAW-1:0]   base_q;

	// history walk
	logic [PW-1:0]    rpos_q, opos_q;
	logic [PW-1:0]    new_head_q;
	logic [FW-1:0]    new_fill_q;
	logic [1:0]       rd_cnt_q;
	logic             rd_vld_s1;
	logic [SUM_W-1:0] recent_q, old_q;

	// output register
	result_t          res_q, res_d;
	logic             out_valid_q;

	// memory ports
	logic             slot_rd_en, slot_wr_en;
	logic [SW-1:0]    slot_wr_addr;
	logic [REC_W-1:0] slot_wr_data, slot_rd_data, rec_upd;
	logic             hist_wr_en, hist_rd_en;
	logic [LAT_W-1:0] hist_rd_a, hist_rd_b;

	// slot record fields
	logic             rec_valid, rec_degr, rec_flood;
	logic [7:0]       rec_fail;
	logic [6:0]       rec_score;
	logic [PW-1:0]    rec_head;
	logic [FW-1:0]    rec_fill;

	// lookup and finish logic
	logic             report_hit, apply, fin_go, surge, flood_new, ok;
	logic [7:0]       fail_new;
	logic             degr_new;
	logic [PW-1:0]    head_next;
	logic [FW-1:0]    fill_next;
	logic [TW-1:0]    start_sum;
	logic [PW-1:0]    start_pos;
	eval_t            ev;

	assign in_item = metrics_t'(s_tdata);
	assign {rec_valid, rec_fail, rec_degr, rec_flood, rec_score, rec_head, rec_fill} =
		slot_rd_data;

	hhm_slot_mem #(
		.DEPTH (HOST_SLOTS),
		.WIDTH (REC_W)
	) u_slot_mem (
		.clk     (clk),
		.wr_en   (slot_wr_en),
		.wr_addr (slot_wr_addr),
		.wr_data (slot_wr_data),
		.rd_en   (slot_rd_en),
		.rd_addr (SW'(in_item.host_slot)),
		.rd_data (slot_rd_data)
	);

	hhm_hist_mem #(
		.DEPTH (HIST_N)
	) u_hist_mem (
		.clk       (clk),
		.wr_en     (hist_wr_en),
		.wr_addr   (base_q + HAW'(rec_head)),
		.wr_data   (item_q.latency),
		.rd_en     (hist_rd_en),
		.rd_addr_a (base_q + HAW'(rpos_q)),
		.rd_addr_b (base_q + HAW'(opos_q)),
		.rd_data_a (hist_rd_a),
		.rd_data_b (hist_rd_b)
	);

	hhm_eval u_eval (
		.clk    (clk),
		.item   (item_q),
		.limits (limits_q),
		.result (ev)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.flood_en   <= 1'(RST_FLOOD_EN);
			limits_q.rate_limit <= 16'(RST_RATE_LIMIT);
			limits_q.lat_limit  <= 16'(RST_LAT_LIMIT);
			limits_q.jit_limit  <= 16'(RST_JIT_LIMIT);
			limits_q.bw_floor   <= 16'(RST_BW_FLOOR);
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FLOOD_EN:   limits_q.flood_en   <= cfg_wdata[0];
				CFG_RATE_LIMIT: limits_q.rate_limit <= cfg_wdata;
				CFG_LAT_LIMIT:  limits_q.lat_limit  <= cfg_wdata;
				CFG_JIT_LIMIT:  limits_q.jit_limit  <= cfg_wdata;
				CFG_BW_FLOOR:   limits_q.bw_floor   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// lookup: history pointers after the push
	assign report_hit = in_range_q && (op_q == OP_REPORT) && rec_valid;
	assign head_next  = (rec_head == PW'(HISTORY_DEPTH - 1)) ? '0 : rec_head + 1'b1;
	assign fill_next  = (rec_fill < FW'(HISTORY_DEPTH)) ? rec_fill + 1'b1 : rec_fill;
	// oldest entry: head_next - fill_next, modulo the depth
	assign start_sum  = TW'(rec_head) + TW'(1) + TW'(HISTORY_DEPTH) - TW'(fill_next);
	assign start_pos  = (start_sum >= TW'(HISTORY_DEPTH)) ?
		PW'(start_sum - TW'(HISTORY_DEPTH)) : PW'(start_sum);

	// finish: flood flag, validation and failure tracking
	assign surge = (new_fill_q >= FW'(SURGE_WINDOW))
		&& (SURGE_W'(recent_q) > SURGE_W'(old_q) * SURGE_W'(SURGE_FACTOR));
	assign flood_new = limits_q.flood_en ? (ev.rate_over || surge) : rec_flood;
	assign ok        = ev.limits_ok && !flood_new;
	assign fail_new  = ok ? '0 : ((rec_fail == 8'(FAIL_MAX)) ? rec_fail : rec_fail + 1'b1);
	assign degr_new  = ok ? 1'b0 : (rec_degr || (fail_new >= 8'(FAIL_DEGRADE)));

	// record to write back and result to deliver
	always_comb begin
		apply   = 1'b0;
		rec_upd = '0;
		res_d   = '0;
		case (op_q)
			OP_REGISTER: begin
				apply   = in_range_q;
				rec_upd = {1'b1, (REC_W - 1)'(0)};
			end
			OP_UNREGISTER: begin
				apply = in_range_q && rec_valid;
			end
			OP_REPORT: begin
				apply   = report_hit;
				rec_upd = {1'b1, fail_new, degr_new, flood_new, ev.score, new_head_q,
					new_fill_q};
				if (report_hit) begin
					res_d.score           = ev.score;
					res_d.report_ok       = ok;
					res_d.degraded        = degr_new;
					res_d.failure_count   = fail_new;
					res_d.flood_suspected = flood_new;
				end
			end
			default: ;
		endcase
		res_d.accepted = apply;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_cnt_q == SW'(HOST_SLOTS - 1)) state_d = ST_IDLE;
			ST_IDLE:   if (s_tvalid) state_d = ST_LOOKUP;
			ST_LOOKUP: state_d = report_hit ? ST_READ : ST_FINISH;
			ST_READ:   if (rd_cnt_q == 2'd2) state_d = ST_SUM;
			ST_SUM:    state_d = ST_FINISH;
			ST_FINISH: if (fin_go) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready     = 1'b0;
		slot_rd_en   = 1'b0;
		slot_wr_en   = 1'b0;
		slot_wr_addr = slot_q;
		slot_wr_data = rec_upd;
		hist_wr_en   = 1'b0;
		hist_rd_en   = 1'b0;
		fin_go       = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				slot_wr_en   = 1'b1;
				slot_wr_addr = clr_cnt_q;
				slot_wr_data = '0;
			end
			ST_IDLE: begin
				s_tready   = 1'b1;
				slot_rd_en = s_tvalid;
			end
			ST_LOOKUP: begin
				hist_wr_en = report_hit;
			end
			ST_READ: begin
				hist_rd_en = 1'b1;
			end
			ST_FINISH: begin
				fin_go     = !out_valid_q || m_tready;
				slot_wr_en = fin_go && apply;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			rd_cnt_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= hist_rd_en;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (state_q == ST_READ) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end else begin
				rd_cnt_q <= '0;
			end
		end
	end

	// item capture and history walk
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			item_q     <= in_item;
			op_q       <= op_t'(s_tuser);
			in_range_q <= (32'(in_item.host_slot) < 32'(HOST_SLOTS));
			slot_q     <= SW'(in_item.host_slot);
			base_q     <= HAW'(SW'(in_item.host_slot)) * HAW'(HISTORY_DEPTH);
		end
		if (state_q == ST_LOOKUP) begin
			rpos_q     <= rec_head;
			opos_q     <= start_pos;
			new_head_q <= head_next;
			new_fill_q <= fill_next;
			recent_q   <= '0;
			old_q      <= '0;
		end
		if (state_q == ST_READ) begin
			// newest walk downward, oldest walk upward
			rpos_q <= (rpos_q == '0) ? PW'(HISTORY_DEPTH - 1) : rpos_q - 1'b1;
			opos_q <= (opos_q == PW'(HISTORY_DEPTH - 1)) ? '0 : opos_q + 1'b1;
		end
		if (rd_vld_s1) begin
			recent_q <= recent_q + SUM_W'(hist_rd_a);
			old_q    <= old_q + SUM_W'(hist_rd_b);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDATA_OUT_W'(res_q);

endmodule
